### rtl/sbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding box sum package
// Shared widths, register indexes, reset values and the item flag struct.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COLSUM_W   = 26;
	localparam int ROWSUM_W   = 31;
	localparam int SUM_W      = 46;
	localparam int GRID_CFG_W = 11;
	localparam int WIN_CFG_W  = 6;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

	localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RST   = 11'd1024;
	localparam logic [WIN_CFG_W-1:0]  WINDOW_SIZE_RST = 6'd3;

	// Classification of one item, made when it is accepted.
	typedef struct packed {
		logic first_col; // column zero: the row sum restarts
		logic row0;      // row zero: column sums start from zero
		logic hist_ok;   // row at or beyond m: the stored sample leaves the column sum
		logic col_ge_m;  // column at or beyond m: a column sum leaves the row sum
		logic emit;      // a full window ends here
		logic last;      // final sample of the grid
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

endpackage
`default_nettype wire

### rtl/sbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and a read at
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                                      clk,
	input  wire logic                                      wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                          wr_data,
	input  wire logic                                      rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

### rtl/sbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding box sum front end
// Holds the configuration, tracks the grid position and classifies each
// accepted item for the back end.
// ----------------------------------------------------------------------------
module sbs_front #(
	parameter int MAX_GRID   = 1024,
	parameter int MAX_WINDOW = 32,
	localparam int GW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1,
	localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int AW = (MAX_WINDOW * MAX_GRID > 1) ? $clog2(MAX_WINDOW * MAX_GRID) : 1
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [sbs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [sbs_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   q_full,
	output logic                                        push,
	output sbs_pkg::item_flags_t                        flags,
	output logic [GW-1:0]                               col,
	output logic [AW-1:0]                               slot,
	output logic [WW-1:0]                               tap
);

	logic [sbs_pkg::GRID_CFG_W-1:0] grid_size_q;
	logic [sbs_pkg::WIN_CFG_W-1:0]  window_size_q;
	logic [31:0]                    n_full;
	logic [31:0]                    m_full;
	logic [GW-1:0]                  nm1;
	logic [WW-1:0]                  mm1;
	logic [GW-1:0]                  row_q;
	logic [GW-1:0]                  col_q;
	logic [WW-1:0]                  rs_q;
	logic                           col_end;
	logic                           row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q   <= sbs_pkg::GRID_SIZE_RST;
			window_size_q <= sbs_pkg::WINDOW_SIZE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				sbs_pkg::REG_GRID_SIZE: begin
					grid_size_q <= cfg_data[sbs_pkg::GRID_CFG_W-1:0];
				end
				sbs_pkg::REG_WINDOW_SIZE: begin
					window_size_q <= cfg_data[sbs_pkg::WIN_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Out-of-range sizes are clamped into 1..MAX.
	always_comb begin
		if (grid_size_q == '0) begin
			n_full = 32'd1;
		end else if (32'(grid_size_q) > 32'(MAX_GRID)) begin
			n_full = 32'(MAX_GRID);
		end else begin
			n_full = 32'(grid_size_q);
		end
		if (window_size_q == '0) begin
			m_full = 32'd1;
		end else if (32'(window_size_q) > 32'(MAX_WINDOW)) begin
			m_full = 32'(MAX_WINDOW);
		end else begin
			m_full = 32'(window_size_q);
		end
	end

	assign nm1 = GW'(n_full - 32'd1);
	assign mm1 = WW'(m_full - 32'd1);
	assign tap = mm1;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign col_end = (col_q == nm1);
	assign row_end = (row_q == nm1);

	// rs_q follows the row index modulo m and picks the history row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			rs_q  <= '0;
		end else if (cfg_write) begin
			row_q <= '0;
			col_q <= '0;
			rs_q  <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
					rs_q  <= '0;
				end else begin
					row_q <= row_q + GW'(1);
					rs_q  <= (rs_q == mm1) ? '0 : rs_q + WW'(1);
				end
			end else begin
				col_q <= col_q + GW'(1);
			end
		end
	end

	always_comb begin
		flags.first_col = (col_q == '0);
		flags.row0      = (row_q == '0);
		flags.hist_ok   = (32'(row_q) > 32'(mm1));
		flags.col_ge_m  = (32'(col_q) > 32'(mm1));
		flags.emit      = (32'(row_q) >= 32'(mm1)) && (32'(col_q) >= 32'(mm1));
		flags.last      = col_end && row_end;
	end

	assign col  = col_q;
	assign slot = AW'(32'(rs_q) * 32'(MAX_GRID) + 32'(col_q));

endmodule
`default_nettype wire

### rtl/sbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding box sum item queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sbs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

### rtl/sbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding box sum back end
// Four-step pipeline: history and column-sum reads, column-sum update,
// row-sum update, then result output with the grand total.
// ----------------------------------------------------------------------------
module sbs_back #(
	parameter int MAX_GRID   = 1024,
	parameter int MAX_WINDOW = 32,
	localparam int GW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1,
	localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int AW = (MAX_WINDOW * MAX_GRID > 1) ? $clog2(MAX_WINDOW * MAX_GRID) : 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 grid_clear,
	input  wire logic [WW-1:0]                        tap,
	input  wire logic                                 q_empty,
	output logic                                      pop,
	input  wire sbs_pkg::item_flags_t                 q_flags,
	input  wire logic signed [sbs_pkg::SAMPLE_W-1:0]  q_sample,
	input  wire logic [GW-1:0]                        q_col,
	input  wire logic [AW-1:0]                        q_slot,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sbs_pkg::SUM_W-1:0]          sum_value,
	output logic                                      is_total,
	output logic                                      last
);

	localparam int SPW = sbs_pkg::SAMPLE_W;
	localparam int CSW = sbs_pkg::COLSUM_W;
	localparam int RSW = sbs_pkg::ROWSUM_W;
	localparam int SW  = sbs_pkg::SUM_W;

	logic                  en;

	// Read step.
	logic                  valid_s1;
	sbs_pkg::item_flags_t  flags_s1;
	logic signed [SPW-1:0] sample_s1;
	logic [GW-1:0]         col_s1;
	logic [AW-1:0]         slot_s1;
	logic [SPW-1:0]        hist_rd;
	logic [CSW-1:0]        cs_rd;

	// Column-sum step.
	logic signed [SPW-1:0] hist_old;
	logic signed [CSW-1:0] cs_old;
	logic signed [CSW-1:0] cs_new;
	logic signed [CSW-1:0] sample_ext;
	logic signed [CSW-1:0] hist_ext;
	logic                  valid_s2;
	sbs_pkg::item_flags_t  flags_s2;
	logic signed [SPW-1:0] sample_s2;
	logic [GW-1:0]         col_s2;
	logic [AW-1:0]         slot_s2;
	logic signed [CSW-1:0] cs_s2;

	// Row-sum step.
	logic signed [CSW-1:0] dl_q [MAX_WINDOW];
	logic signed [RSW-1:0] rrs_q;
	logic signed [RSW-1:0] rrs_base;
	logic signed [RSW-1:0] rrs_add;
	logic signed [RSW-1:0] rrs_sub;
	logic signed [RSW-1:0] rrs_new;
	logic                  valid_s3;
	sbs_pkg::item_flags_t  flags_s3;

	// Output step.
	logic signed [SW-1:0]  rrs_ext;
	logic signed [SW-1:0]  gt_q;
	logic signed [SW-1:0]  gt_sum;
	logic                  out_valid_q;
	logic signed [SW-1:0]  out_sum_q;
	logic                  out_total_q;
	logic                  out_last_q;
	logic                  pend_q;
	logic signed [SW-1:0]  pend_sum_q;

	// The whole pipeline moves together; it holds while a result waits.
	assign en  = !pend_q && (!out_valid_q || !out_stall);
	assign pop = en && !q_empty;

	sbs_ram #(
		.WIDTH(SPW),
		.DEPTH(MAX_WINDOW * MAX_GRID)
	) u_hist_ram (
		.clk    (clk),
		.wr_en  (en && valid_s1),
		.wr_addr(slot_s1),
		.wr_data(sample_s1),
		.rd_en  (pop),
		.rd_addr(q_slot),
		.rd_data(hist_rd)
	);

	sbs_ram #(
		.WIDTH(CSW),
		.DEPTH(MAX_GRID)
	) u_colsum_ram (
		.clk    (clk),
		.wr_en  (en && valid_s1),
		.wr_addr(col_s1),
		.wr_data(cs_new),
		.rd_en  (pop),
		.rd_addr(q_col),
		.rd_data(cs_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1  <= q_flags;
			sample_s1 <= q_sample;
			col_s1    <= q_col;
			slot_s1   <= q_slot;
			flags_s2  <= flags_s1;
			sample_s2 <= sample_s1;
			col_s2    <= col_s1;
			slot_s2   <= slot_s1;
			cs_s2     <= cs_new;
			flags_s3  <= flags_s2;
		end
	end

	// The item one step ahead wrote its RAM entries on the edge that read
	// ours, so a match against it is forwarded. Row zero starts each column
	// sum from zero, which stands in for clearing the column sums per grid.
	always_comb begin
		if (!flags_s1.hist_ok) begin
			hist_old = '0;
		end else if (valid_s2 && (slot_s2 == slot_s1)) begin
			hist_old = sample_s2;
		end else begin
			hist_old = signed'(hist_rd);
		end
		if (flags_s1.row0) begin
			cs_old = '0;
		end else if (valid_s2 && (col_s2 == col_s1)) begin
			cs_old = cs_s2;
		end else begin
			cs_old = signed'(cs_rd);
		end
	end

	assign sample_ext = CSW'(sample_s1);
	assign hist_ext   = CSW'(hist_old);
	assign cs_new     = cs_old + sample_ext - hist_ext;

	// dl_q[k] holds the column sum k+1 columns back in the current row.
	assign rrs_base = flags_s2.first_col ? '0 : rrs_q;
	assign rrs_add  = RSW'(cs_s2);
	assign rrs_sub  = flags_s2.col_ge_m ? RSW'(dl_q[tap]) : '0;
	assign rrs_new  = rrs_base + rrs_add - rrs_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rrs_q <= '0;
		end else if (en && valid_s2) begin
			rrs_q <= rrs_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			dl_q[0] <= cs_s2;
			for (int k = 1; k < MAX_WINDOW; k++) begin
				dl_q[k] <= dl_q[k-1];
			end
		end
	end

	assign rrs_ext = SW'(rrs_q);
	assign gt_sum  = gt_q + (flags_s3.emit ? rrs_ext : '0);

	// A final item that also ends a window gives two results; the total
	// waits in pend_sum_q while the window sum is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			gt_q        <= '0;
		end else begin
			if (pend_q) begin
				if (!out_stall) begin
					out_valid_q <= 1'b1;
					pend_q      <= 1'b0;
				end
			end else if (en) begin
				out_valid_q <= valid_s3 && (flags_s3.emit || flags_s3.last);
				if (valid_s3) begin
					pend_q <= flags_s3.emit && flags_s3.last;
					gt_q   <= flags_s3.last ? '0 : gt_sum;
				end
			end
			if (grid_clear) begin
				gt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			if (!out_stall) begin
				out_sum_q   <= pend_sum_q;
				out_total_q <= 1'b1;
				out_last_q  <= 1'b1;
			end
		end else if (en && valid_s3) begin
			if (flags_s3.emit) begin
				out_sum_q   <= rrs_ext;
				out_total_q <= 1'b0;
				out_last_q  <= 1'b0;
				pend_sum_q  <= gt_sum;
			end else begin
				out_sum_q   <= gt_sum;
				out_total_q <= 1'b1;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sum_value = out_sum_q;
	assign is_total  = out_total_q;
	assign last      = out_last_q;

`ifndef NO_ASSERTIONS
	a_pend_behind_window: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && !out_total_q))
		else $error("pending total without a window sum ahead of it");

	a_total_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_total_q == out_last_q))
		else $error("total and last flags disagree");
`endif

endmodule
`default_nettype wire

### rtl/sliding_box_sum_2d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding two-dimensional box sum
// Sums every m-by-m window of an n-by-n raster grid and ends each grid with
// the total of all window sums.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  input    in_valid/in_stall   sample
//  output   out_valid/out_stall sum_value, is_total, last
//  config   cfg_write           cfg_index, cfg_data
//
//  One sample is taken every cycle while in_stall is low; a window sum reaches
//  the output through the queue and the read, column-sum, row-sum and output
//  steps. The grid's final sample gives two results when it also ends a
//  window, since the window sum and the total share one output register.
//  Column sums need no clearing pass: row zero of each grid starts them at
//  zero. Output stalls hold the back-end pipeline; the four-item queue then
//  fills before in_stall rises.
// ----------------------------------------------------------------------------
module sliding_box_sum_2d_core #(
	parameter int MAX_GRID   = 1024,
	parameter int MAX_WINDOW = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [sbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sbs_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [sbs_pkg::SAMPLE_W-1:0]  sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sbs_pkg::SUM_W-1:0]          sum_value,
	output logic                                      is_total,
	output logic                                      last
);

	localparam int GW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
	localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int AW = (MAX_WINDOW * MAX_GRID > 1) ? $clog2(MAX_WINDOW * MAX_GRID) : 1;
	localparam int SPW = sbs_pkg::SAMPLE_W;
	localparam int FW  = sbs_pkg::FLAGS_W;
	localparam int QW  = FW + SPW + GW + AW;

	logic                  q_full;
	logic                  q_empty;
	logic                  push;
	logic                  pop;
	sbs_pkg::item_flags_t  fr_flags;
	logic [GW-1:0]         fr_col;
	logic [AW-1:0]         fr_slot;
	logic [WW-1:0]         tap;
	logic [QW-1:0]         q_head;
	sbs_pkg::item_flags_t  bk_flags;
	logic signed [SPW-1:0] bk_sample;
	logic [GW-1:0]         bk_col;
	logic [AW-1:0]         bk_slot;

	sbs_front #(
		.MAX_GRID  (MAX_GRID),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_full   (q_full),
		.push     (push),
		.flags    (fr_flags),
		.col      (fr_col),
		.slot     (fr_slot),
		.tap      (tap)
	);

	sbs_queue #(
		.WIDTH(QW),
		.DEPTH(sbs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({fr_flags, sample, fr_col, fr_slot}),
		.full   (q_full),
		.pop    (pop),
		.rd_data(q_head),
		.empty  (q_empty)
	);

	assign {bk_flags, bk_sample, bk_col, bk_slot} = q_head;

	sbs_back #(
		.MAX_GRID  (MAX_GRID),
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_clear(cfg_write),
		.tap       (tap),
		.q_empty   (q_empty),
		.pop       (pop),
		.q_flags   (bk_flags),
		.q_sample  (bk_sample),
		.q_col     (bk_col),
		.q_slot    (bk_slot),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum_value (sum_value),
		.is_total  (is_total),
		.last      (last)
	);

endmodule
`default_nettype wire
